// ===== rtl/core/ufdc_pkg.sv =====
package ufdc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;

  localparam logic [ByteW-1:0] SyncByte     = 8'hAA;
  localparam logic [ByteW-1:0] CheckBase    = 8'hFF;
  localparam logic [ByteW-1:0] OpcLocalAddr = 8'h0A;
  localparam logic [ByteW-1:0] OpcLinkStat  = 8'h0C;

  typedef enum logic [KindW-1:0] {
    KIND_UNKNOWN    = 2'd0,
    KIND_LOCAL_ADDR = 2'd1,
    KIND_LINK_STAT  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    PH_SYNC    = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CHECK   = 4'b1000
  } phase_e;

  function automatic kind_e class_of(input logic [ByteW-1:0] op);
    kind_e k;
    priority if (op == OpcLocalAddr) k = KIND_LOCAL_ADDR;
    else if (op == OpcLinkStat)      k = KIND_LINK_STAT;
    else                             k = KIND_UNKNOWN;
    return k;
  endfunction

endpackage

// ===== rtl/core/uart_frame_deframer_checksum.sv =====
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+---------------------------------------------
// input    | in_valid_i / in_ready_o     | rx_byte_i
// output   | out_valid_o / out_ready_i   | data_byte_o, byte_index_o, is_last_o,
//          |                             | checksum_ok_o, event_kind_o, frame_length_o
//
// One byte per cycle: the frame state updates at the accepting edge, and a
// payload or checksum byte loads the result register in that same edge.
// For a payload or checksum byte, out_valid_o rises in the cycle after the accept.
// A new byte is taken whenever the result register is empty or being drained.
// Reset returns the parser to waiting for sync and drops any pending result.
module uart_frame_deframer_checksum (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [7:0] byte_index_o,
  output logic       is_last_o,
  output logic       checksum_ok_o,
  output logic [1:0] event_kind_o,
  output logic [7:0] frame_length_o
);

  ufdc_pkg::phase_e          phase_q, phase_d;
  logic [ufdc_pkg::ByteW-1:0] len_q, len_d;
  logic [ufdc_pkg::ByteW-1:0] cnt_q, cnt_d;
  logic [ufdc_pkg::ByteW-1:0] sum_q, sum_d;
  ufdc_pkg::kind_e           kind_q, kind_d;

  logic                       out_valid_q, out_valid_d;
  logic [ufdc_pkg::ByteW-1:0] data_q, data_d;
  logic [ufdc_pkg::ByteW-1:0] idx_q, idx_d;
  logic                       last_q, last_d;
  logic                       ok_q, ok_d;
  ufdc_pkg::kind_e           okind_q, okind_d;
  logic [ufdc_pkg::ByteW-1:0] olen_q, olen_d;

  logic                       in_acc;
  logic                       emit;
  logic [ufdc_pkg::ByteW-1:0] cnt_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    kind_d  = kind_q;
    emit    = 1'b0;
    data_d  = data_q;
    idx_d   = idx_q;
    last_d  = last_q;
    ok_d    = ok_q;
    okind_d = okind_q;
    olen_d  = olen_q;
    if (in_acc) begin
      unique case (phase_q)
        ufdc_pkg::PH_SYNC: begin
          if (rx_byte_i == ufdc_pkg::SyncByte) phase_d = ufdc_pkg::PH_LENGTH;
        end
        ufdc_pkg::PH_LENGTH: begin
          len_d   = rx_byte_i;
          sum_d   = rx_byte_i;
          cnt_d   = '0;
          kind_d  = ufdc_pkg::KIND_UNKNOWN;
          phase_d = (rx_byte_i == '0) ? ufdc_pkg::PH_CHECK : ufdc_pkg::PH_PAYLOAD;
        end
        ufdc_pkg::PH_PAYLOAD: begin
          // first payload byte is the opcode and sets the frame class
          if (cnt_q == '0) kind_d = ufdc_pkg::class_of(rx_byte_i);
          sum_d = sum_q + rx_byte_i;
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) phase_d = ufdc_pkg::PH_CHECK;
          emit    = 1'b1;
          data_d  = rx_byte_i;
          idx_d   = cnt_q;
          last_d  = 1'b0;
          ok_d    = 1'b0;
          okind_d = kind_d;
          olen_d  = len_q;
        end
        ufdc_pkg::PH_CHECK: begin
          emit    = 1'b1;
          data_d  = rx_byte_i;
          idx_d   = len_q;
          last_d  = 1'b1;
          ok_d    = ((ufdc_pkg::CheckBase - sum_q) == rx_byte_i);
          okind_d = kind_q;
          olen_d  = len_q;
          phase_d = ufdc_pkg::PH_SYNC;
        end
        default: phase_d = ufdc_pkg::PH_SYNC;
      endcase
    end
    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ufdc_pkg::PH_SYNC;
      len_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      kind_q      <= ufdc_pkg::KIND_UNKNOWN;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    idx_q   <= idx_d;
    last_q  <= last_d;
    ok_q    <= ok_d;
    okind_q <= okind_d;
    olen_q  <= olen_d;
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = data_q;
  assign byte_index_o   = idx_q;
  assign is_last_o      = last_q;
  assign checksum_ok_o  = ok_q;
  assign event_kind_o   = okind_q;
  assign frame_length_o = olen_q;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register lost its one-hot code");

  a_check_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (phase_q == ufdc_pkg::PH_CHECK)
    |=> (phase_q == ufdc_pkg::PH_SYNC) && out_valid_q && last_q)
    else $error("checksum byte did not close the frame");

  a_sync_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((phase_q == ufdc_pkg::PH_SYNC) || (phase_q == ufdc_pkg::PH_LENGTH))
    |=> out_valid_q == $past(out_valid_q && !out_ready_i))
    else $error("sync or length byte produced a result");

  a_ok_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ok_q |-> last_q)
    else $error("checksum verdict on a payload item");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !last_q |-> idx_q < olen_q)
    else $error("payload index beyond frame length");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TargetItems = 900;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic [7:0] value;
    logic       drain_first;
  } rx_item_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [7:0]      byte_index;
    logic            is_last;
    logic            checksum_ok;
    ufdc_pkg::kind_e event_kind;
    logic [7:0]      frame_length;
  } frame_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] data_byte_o;
  logic [7:0] byte_index_o;
  logic       is_last_o;
  logic       checksum_ok_o;
  logic [1:0] event_kind_o;
  logic [7:0] frame_length_o;

  rx_item_t      rx_pending[$];
  frame_result_t frame_results[$];
  int unsigned   bytes_taken = 0;
  int unsigned   total_bytes = 1;
  int unsigned   fail_count = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   stim_items = 0;
  logic          drain_next = 1'b0;

  // deframer state as the testbench tracks it
  ufdc_pkg::phase_e fr_phase = ufdc_pkg::PH_SYNC;
  logic [7:0]       fr_len = 8'h00;
  logic [7:0]       fr_count = 8'h00;
  logic [7:0]       fr_sum = 8'h00;
  ufdc_pkg::kind_e  fr_kind = ufdc_pkg::KIND_UNKNOWN;

  uart_frame_deframer_checksum uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .is_last_o     (is_last_o),
    .checksum_ok_o (checksum_ok_o),
    .event_kind_o  (event_kind_o),
    .frame_length_o(frame_length_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic ufdc_pkg::kind_e opcode_kind(input logic [7:0] op);
    ufdc_pkg::kind_e k;
    case (op)
      ufdc_pkg::OpcLocalAddr: k = ufdc_pkg::KIND_LOCAL_ADDR;
      ufdc_pkg::OpcLinkStat:  k = ufdc_pkg::KIND_LINK_STAT;
      default:                k = ufdc_pkg::KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // Idle percentage: sender 35 then 77 then 0, receiver 77 then 35 then 0.
  function automatic int unsigned idle_pct(input logic sender);
    int unsigned third;
    third = (bytes_taken * 3) / total_bytes;
    if (third == 0) return sender ? 35 : 77;
    if (third == 1) return sender ? 77 : 35;
    return 0;
  endfunction

  task automatic track_byte(input logic [7:0] b);
    frame_result_t r;
    case (fr_phase)
      ufdc_pkg::PH_SYNC: begin
        if (b == ufdc_pkg::SyncByte) fr_phase = ufdc_pkg::PH_LENGTH;
      end
      ufdc_pkg::PH_LENGTH: begin
        fr_len   = b;
        fr_sum   = b;
        fr_count = 8'h00;
        fr_kind  = ufdc_pkg::KIND_UNKNOWN;
        if (b == 8'h00) fr_phase = ufdc_pkg::PH_CHECK;
        else fr_phase = ufdc_pkg::PH_PAYLOAD;
      end
      ufdc_pkg::PH_PAYLOAD: begin
        if (fr_count == 8'h00) fr_kind = opcode_kind(b);
        fr_sum = fr_sum + b;
        r = '{data_byte: b, byte_index: fr_count, is_last: 1'b0, checksum_ok: 1'b0,
              event_kind: fr_kind, frame_length: fr_len};
        fr_count = fr_count + 8'd1;
        if (fr_count >= fr_len) fr_phase = ufdc_pkg::PH_CHECK;
        frame_results.push_back(r);
      end
      default: begin
        r = '{data_byte: b, byte_index: fr_len, is_last: 1'b1,
              checksum_ok: ((ufdc_pkg::CheckBase - fr_sum) == b), event_kind: fr_kind,
              frame_length: fr_len};
        fr_phase = ufdc_pkg::PH_SYNC;
        frame_results.push_back(r);
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_pending.push_back('{value: b, drain_first: drain_next});
    drain_next = 1'b0;
  endtask

  // sync, length, body, checksum; a bad checksum has one bit flipped
  task automatic push_frame(input octet_q_t body, input logic good);
    logic [7:0] sum;
    logic [7:0] cs;
    sum = 8'(body.size());
    push_byte(ufdc_pkg::SyncByte);
    push_byte(8'(body.size()));
    foreach (body[i]) begin
      sum = sum + body[i];
      push_byte(body[i]);
    end
    cs = ufdc_pkg::CheckBase - sum;
    if (!good) cs = cs ^ (8'h01 << $urandom_range(0, 7));
    push_byte(cs);
    stim_items += body.size() + 3;
  endtask

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 2))
      0:       return ufdc_pkg::OpcLocalAddr;
      1:       return ufdc_pkg::OpcLinkStat;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // sender
  always @(posedge clk_i) begin
    logic     busy;
    rx_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        track_byte(rx_byte_i);
        bytes_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (rx_pending.size() != 0 &&
            !(rx_pending[0].drain_first && frame_results.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          nxt = rx_pending.pop_front();
          rx_byte_i  <= nxt.value;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    frame_result_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (frame_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual data %0h index %0h last %0b",
                   $time, data_byte_o, byte_index_o, is_last_o);
          fail_count++;
        end else begin
          exp_r = frame_results.pop_front();
          check_field("data_byte", exp_r.data_byte, data_byte_o);
          check_field("byte_index", exp_r.byte_index, byte_index_o);
          check_field("is_last", 8'(exp_r.is_last), 8'(is_last_o));
          check_field("checksum_ok", 8'(exp_r.checksum_ok), 8'(checksum_ok_o));
          check_field("event_kind", 8'(exp_r.event_kind), 8'(event_kind_o));
          check_field("frame_length", exp_r.frame_length, frame_length_o);
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: timeout after %0d idle cycles", $time, stall_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    octet_q_t   body;
    int unsigned pick;
    int unsigned len;
    logic       long_done;

    long_done = 1'b0;

    // bytes before sync are dropped
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h55);
    // zero length, good checksum
    body.delete();
    push_frame(body, 1'b1);
    // local address event
    body.delete();
    body.push_back(ufdc_pkg::OpcLocalAddr);
    push_frame(body, 1'b1);
    // link status with sync value in the payload, bad checksum
    body.delete();
    body.push_back(ufdc_pkg::OpcLinkStat);
    body.push_back(ufdc_pkg::SyncByte);
    push_frame(body, 1'b0);
    // unknown opcode, extreme byte values
    body.delete();
    body.push_back(8'h00);
    body.push_back(8'hFF);
    push_frame(body, 1'b1);
    // zero length with sync value as checksum
    push_byte(ufdc_pkg::SyncByte);
    push_byte(8'h00);
    push_byte(ufdc_pkg::SyncByte);

    drain_next = 1'b1;
    while (stim_items < TargetItems) begin
      pick = $urandom_range(0, 99);
      if (stim_items > TargetItems / 2 && !long_done) begin
        // longest frame, sent after a full drain
        drain_next = 1'b1;
        body.delete();
        body.push_back(pick_opcode());
        for (int i = 1; i < 255; i++) body.push_back(8'($urandom_range(0, 255)));
        push_frame(body, 1'($urandom_range(0, 1)));
        long_done = 1'b1;
      end else if (pick < 8) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 13) begin
        // truncated frame; what follows is parsed as its tail
        push_byte(ufdc_pkg::SyncByte);
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 20)));
        stim_items += len + 1;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        body.delete();
        if (len != 0) body.push_back(pick_opcode());
        for (int i = 1; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
        push_frame(body, $urandom_range(0, 99) < 80);
      end
    end
    total_bytes = rx_pending.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (frame_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ufdc_pkg.sv
rtl/core/uart_frame_deframer_checksum.sv
tb/tb.sv
